@@ rtl/lade_pkg.sv @@
// ----------------------------------------------------------------------------
// lade_pkg
// Shared types and constants for the action record delta encoder.
// ----------------------------------------------------------------------------
package lade_pkg;

    localparam int unsigned NUM_BYTES = 11;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_UNKNOWN_CODE = 2'd0;
    localparam logic [1:0] REG_SYNC_CODE    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    // Fixed byte positions of a record before absent bytes are skipped.
    localparam int unsigned POS_HEAD    = 0;
    localparam int unsigned POS_CUSTOM  = 1;
    localparam int unsigned POS_HDR     = 2;
    localparam int unsigned POS_SLOT_2  = 3;
    localparam int unsigned POS_SLOT_1  = 4;
    localparam int unsigned POS_SLOT_0  = 5;
    localparam int unsigned POS_DIFF_1  = 6;
    localparam int unsigned POS_DIFF_0  = 7;
    localparam int unsigned POS_USED    = 8;
    localparam int unsigned POS_PLEN_1  = 9;
    localparam int unsigned POS_PLEN_0  = 10;

    // Header bits.
    localparam int unsigned HDR_SLOT_IDX    = 0;
    localparam int unsigned HDR_SLOTS_USED  = 1;
    localparam int unsigned HDR_SLOT_DIFF   = 2;
    localparam int unsigned HDR_PAYLOAD     = 4;
    localparam int unsigned HDR_NEW_DEFAULT = 5;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [4:0] unknown_code;
        logic [4:0] sync_code;
        logic [7:0] threshold;
    } t_cfg;

    typedef struct packed {
        logic [NUM_BYTES-1:0][7:0] data;
        logic [NUM_BYTES-1:0]      mask;
    } t_rec;

endpackage

@@ rtl/lade_if.sv @@
// ----------------------------------------------------------------------------
// lade_if
// Valid/ready channels for logged actions and for serialized record bytes.
// ----------------------------------------------------------------------------
interface lade_act_if;
    logic        valid;
    logic        ready;
    logic [4:0]  status_code;
    logic [9:0]  custom_code;
    logic [23:0] slot_index;
    logic signed [15:0] slot_difference;
    logic [7:0]  slots_used;
    logic [15:0] payload_length;

    modport source (
        output valid, status_code, custom_code, slot_index, slot_difference,
               slots_used, payload_length,
        input  ready
    );
    modport sink (
        input  valid, status_code, custom_code, slot_index, slot_difference,
               slots_used, payload_length,
        output ready
    );
endinterface

interface lade_rec_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (
        output valid, out_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_byte,
        output ready
    );
endinterface

@@ rtl/lade_cfg.sv @@
// ----------------------------------------------------------------------------
// lade_cfg
// APB register file holding the status codes and the default update threshold.
// ----------------------------------------------------------------------------
module lade_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output lade_pkg::t_cfg  o_cfg
);
    import lade_pkg::*;

    t_cfg r_cfg;
    logic w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unknown_code <= 5'd0;
            r_cfg.sync_code    <= 5'd1;
            r_cfg.threshold    <= 8'd3;
        end else if (w_write) begin
            unique case (paddr[3:2])
                REG_UNKNOWN_CODE: r_cfg.unknown_code <= pwdata[4:0];
                REG_SYNC_CODE:    r_cfg.sync_code    <= pwdata[4:0];
                REG_THRESHOLD:    r_cfg.threshold    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_UNKNOWN_CODE: prdata = {27'd0, r_cfg.unknown_code};
            REG_SYNC_CODE:    prdata = {27'd0, r_cfg.sync_code};
            REG_THRESHOLD:    prdata = {24'd0, r_cfg.threshold};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/lade_encoder.sv @@
// ----------------------------------------------------------------------------
// lade_encoder
// Tracks expected slot and adaptive default, builds one record per item.
// ----------------------------------------------------------------------------
module lade_encoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lade_pkg::t_cfg  i_cfg,
    lade_act_if.sink        i_act,
    input  logic            i_load,
    output logic            o_rec_valid,
    output lade_pkg::t_rec  o_rec
);
    import lade_pkg::*;

    logic [23:0] r_expected;
    logic [7:0]  r_default;
    logic [7:0]  r_cand;
    logic [7:0]  r_count;
    logic        r_rec_valid;
    t_rec        r_rec;

    logic [23:0] n_expected;
    logic [7:0]  n_default;
    logic [7:0]  n_cand;
    logic [7:0]  n_count;
    t_rec        n_rec;

    logic        w_accept;
    logic        w_unknown;
    logic        w_sync;
    logic        w_new_default;
    logic        w_ext;
    logic        w_has_slot;
    logic        w_has_diff;
    logic        w_has_used;
    logic        w_has_plen;
    logic [7:0]  w_count_inc;
    logic [7:0]  w_hdr;
    logic [1:0]  w_custom_hi;

    assign i_act.ready = !r_rec_valid || i_load;
    assign w_accept    = i_act.valid && i_act.ready;
    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

    assign w_unknown   = (i_act.status_code == i_cfg.unknown_code);
    assign w_sync      = (i_act.status_code == i_cfg.sync_code);
    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 8'd1;

    always_comb begin
        n_default     = r_default;
        n_cand        = r_cand;
        n_count       = r_count;
        w_new_default = 1'b0;
        if (i_act.slots_used != r_default) begin
            if (i_act.slots_used != r_cand) begin
                n_cand  = i_act.slots_used;
                n_count = 8'd1;
            end else begin
                n_count = w_count_inc;
                if (w_count_inc >= i_cfg.threshold) begin
                    n_default     = i_act.slots_used;
                    w_new_default = 1'b1;
                end
            end
        end
    end

    assign w_has_slot = w_sync || (i_act.slot_index != r_expected);
    assign w_has_diff = (i_act.slot_difference != 16'sd0);
    assign w_has_used = (i_act.slots_used != n_default) || w_new_default;
    assign w_has_plen = (i_act.payload_length != 16'd0);
    assign w_ext      = w_has_slot || w_has_diff || w_has_used || w_has_plen;
    assign n_expected = i_act.slot_index + {16'd0, i_act.slots_used};
    assign w_custom_hi = w_unknown ? i_act.custom_code[9:8] : 2'b00;

    always_comb begin
        w_hdr                  = 8'd0;
        w_hdr[HDR_SLOT_IDX]    = w_has_slot;
        w_hdr[HDR_SLOTS_USED]  = w_has_used;
        w_hdr[HDR_SLOT_DIFF]   = w_has_diff;
        w_hdr[HDR_PAYLOAD]     = w_has_plen;
        w_hdr[HDR_NEW_DEFAULT] = w_new_default;

        n_rec.data[POS_HEAD]   = {w_ext, i_act.status_code, w_custom_hi};
        n_rec.data[POS_CUSTOM] = i_act.custom_code[7:0];
        n_rec.data[POS_HDR]    = w_hdr;
        n_rec.data[POS_SLOT_2] = i_act.slot_index[23:16];
        n_rec.data[POS_SLOT_1] = i_act.slot_index[15:8];
        n_rec.data[POS_SLOT_0] = i_act.slot_index[7:0];
        n_rec.data[POS_DIFF_1] = i_act.slot_difference[15:8];
        n_rec.data[POS_DIFF_0] = i_act.slot_difference[7:0];
        n_rec.data[POS_USED]   = i_act.slots_used;
        n_rec.data[POS_PLEN_1] = i_act.payload_length[15:8];
        n_rec.data[POS_PLEN_0] = i_act.payload_length[7:0];

        n_rec.mask             = '0;
        n_rec.mask[POS_HEAD]   = 1'b1;
        n_rec.mask[POS_CUSTOM] = w_unknown;
        n_rec.mask[POS_HDR]    = w_ext;
        n_rec.mask[POS_SLOT_2] = w_ext && w_has_slot;
        n_rec.mask[POS_SLOT_1] = w_ext && w_has_slot;
        n_rec.mask[POS_SLOT_0] = w_ext && w_has_slot;
        n_rec.mask[POS_DIFF_1] = w_ext && w_has_diff;
        n_rec.mask[POS_DIFF_0] = w_ext && w_has_diff;
        n_rec.mask[POS_USED]   = w_ext && w_has_used;
        n_rec.mask[POS_PLEN_1] = w_ext && w_has_plen;
        n_rec.mask[POS_PLEN_0] = w_ext && w_has_plen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected  <= 24'd0;
            r_default   <= 8'd1;
            r_cand      <= 8'd1;
            r_count     <= 8'd0;
            r_rec_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_expected  <= n_expected;
                r_default   <= n_default;
                r_cand      <= n_cand;
                r_count     <= n_count;
                r_rec_valid <= 1'b1;
            end else if (i_load) begin
                r_rec_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rec <= n_rec;
        end
    end

    a_head_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_valid |-> r_rec.mask[POS_HEAD])
        else $error("record without a head byte");

    a_ext_matches_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_valid |-> (r_rec.mask[POS_HDR] == r_rec.data[POS_HEAD][7]))
        else $error("extension flag disagrees with header presence");

    a_fields_need_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rec_valid && !r_rec.mask[POS_HDR]) |-> (r_rec.mask[NUM_BYTES-1:POS_SLOT_2] == '0))
        else $error("optional field without header");

    a_default_on_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_new_default) |=> (r_default == $past(i_act.slots_used)))
        else $error("new default not taken over");

endmodule

@@ rtl/lade_serializer.sv @@
// ----------------------------------------------------------------------------
// lade_serializer
// Emits the present bytes of a record in order, one item per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module lade_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rec_valid,
    input  lade_pkg::t_rec  i_rec,
    output logic            o_load,
    lade_rec_if.source      o_rec
);
    import lade_pkg::*;

    logic [NUM_BYTES-1:0]      r_mask;
    logic [NUM_BYTES-1:0][7:0] r_data;
    logic [NUM_BYTES-1:0]      n_mask;

    logic [NUM_BYTES-1:0] w_pick;
    logic [NUM_BYTES-1:0] w_rest;
    logic [7:0]           w_byte;
    logic                 w_take;
    logic                 w_last;

    assign w_pick = r_mask & (-r_mask);
    assign w_rest = r_mask & ~w_pick;
    assign w_last = (w_rest == '0);
    assign w_take = o_rec.valid && o_rec.ready;
    assign o_load = i_rec_valid && ((r_mask == '0) || (w_take && w_last));

    always_comb begin
        w_byte = 8'd0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            w_byte = w_byte | (r_data[i] & {8{w_pick[i]}});
        end
    end

    assign o_rec.valid     = (r_mask != '0);
    assign o_rec.out_byte  = w_byte;
    assign o_rec.last_byte = w_last;

    always_comb begin
        n_mask = r_mask;
        if (o_load) begin
            n_mask = i_rec.mask;
        end else if (w_take) begin
            n_mask = w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_data <= i_rec.data;
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec.valid && !o_rec.ready) |=> $stable(r_mask))
        else $error("pending bytes changed under stall");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_last && !o_load) |=> !o_rec.valid)
        else $error("bytes remain after the last byte");

    a_load_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> r_mask[POS_HEAD])
        else $error("loaded record lacks a head byte");

endmodule

@@ rtl/log_action_delta_encoder.sv @@
// ----------------------------------------------------------------------------
// log_action_delta_encoder
// Turns each logged action into a delta-coded record of 1 to 11 bytes.
// ----------------------------------------------------------------------------
// The block takes one logged action per item on i_act and emits the record
// on o_rec, one byte per item, with last_byte set on the final byte. The
// APB port sets the unknown status code, the sync code and the threshold
// for adopting a new default slot count; write it only while the block is
// idle.
// An accepted action is encoded into the record register, then loaded into
// the byte emitter's mask and data registers, from which its first byte
// goes out on o_rec. The byte emitter sends one byte per cycle while the
// receiver is ready; the next action is taken while the current record
// drains and its first byte follows the last byte of the previous record
// with no gap.
// Reset clears the expected slot to zero, the default and candidate slot
// counts to one, the repeat count to zero and all pending records. When the
// receiver stalls, the current byte holds and one further encoded record
// waits; i_act then stalls.
// ----------------------------------------------------------------------------
module log_action_delta_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lade_act_if.sink    i_act,
    lade_rec_if.source  o_rec
);
    import lade_pkg::*;

    t_cfg w_cfg;
    t_rec w_rec;
    logic w_rec_valid;
    logic w_load;

    lade_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lade_encoder u_encoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_act       (i_act),
        .i_load      (w_load),
        .o_rec_valid (w_rec_valid),
        .o_rec       (w_rec)
    );

    lade_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (w_rec_valid),
        .i_rec       (w_rec),
        .o_load      (w_load),
        .o_rec       (o_rec)
    );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the action record delta encoder.
// ----------------------------------------------------------------------------
// Logged actions are fed through the valid/ready action channel while the
// record channel is drained with random back-pressure. Each accepted action
// is encoded by a local model of the delta coding, and the bytes it yields
// are compared in order with the emitted record bytes. The configuration
// registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import lade_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [4:0]  status;
        logic [9:0]  custom;
        logic [23:0] slot;
        logic [15:0] diff;
        logic [7:0]  used;
        logic [15:0] plen;
    } t_action;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_rec_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lade_act_if act_ch ();
    lade_rec_if rec_ch ();

    log_action_delta_encoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_act   (act_ch),
        .o_rec   (rec_ch)
    );

    // Encoder state as the receiver of the records sees it.
    t_cfg        cfg;
    logic [23:0] exp_slot;
    logic [7:0]  dflt_slots;
    logic [7:0]  cand_slots;
    logic [7:0]  cand_cnt;

    t_action   actions_to_send[$];
    t_rec_byte pending_record_bytes[$];

    logic [23:0] gen_next_slot;
    logic [7:0]  pref_used;
    int          idle_pct;
    int          src_gap;
    int          snk_stall;
    logic        act_taken;
    int          quiet_cycles;
    int          n_actions;
    int          n_bytes;
    int          n_ext;
    int          n_new_dflt;
    int          n_errors;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void encode_action(input t_action a);
        logic       is_unk;
        logic       is_sync;
        logic       new_dflt;
        logic       ext;
        logic [7:0] hdr;
        logic [7:0] rec[$];
        is_unk   = (a.status == cfg.unknown_code);
        is_sync  = (a.status == cfg.sync_code);
        new_dflt = 1'b0;
        hdr      = '0;
        if (a.used != dflt_slots) begin
            if (a.used != cand_slots) begin
                cand_slots = a.used;
                cand_cnt   = 8'd1;
            end else begin
                if (cand_cnt != COUNT_MAX) begin
                    cand_cnt = cand_cnt + 8'd1;
                end
                if (cand_cnt >= cfg.threshold) begin
                    dflt_slots = a.used;
                    new_dflt   = 1'b1;
                end
            end
        end
        ext = (a.slot != exp_slot) || (a.diff != 0) || (a.used != dflt_slots) ||
              new_dflt || (a.plen != 0) || is_sync;
        if (ext) begin
            hdr[HDR_SLOT_IDX]    = is_sync || (a.slot != exp_slot);
            hdr[HDR_SLOT_DIFF]   = (a.diff != 0);
            hdr[HDR_SLOTS_USED]  = (a.used != dflt_slots) || new_dflt;
            hdr[HDR_NEW_DEFAULT] = new_dflt;
            hdr[HDR_PAYLOAD]     = (a.plen != 0);
        end
        rec.push_back({ext, a.status, is_unk ? a.custom[9:8] : 2'b00});
        if (is_unk) begin
            rec.push_back(a.custom[7:0]);
        end
        if (ext) begin
            rec.push_back(hdr);
            if (hdr[HDR_SLOT_IDX]) begin
                rec.push_back(a.slot[23:16]);
                rec.push_back(a.slot[15:8]);
                rec.push_back(a.slot[7:0]);
            end
            if (hdr[HDR_SLOT_DIFF]) begin
                rec.push_back(a.diff[15:8]);
                rec.push_back(a.diff[7:0]);
            end
            if (hdr[HDR_SLOTS_USED]) begin
                rec.push_back(a.used);
            end
            if (hdr[HDR_PAYLOAD]) begin
                rec.push_back(a.plen[15:8]);
                rec.push_back(a.plen[7:0]);
            end
        end
        foreach (rec[i]) begin
            pending_record_bytes.push_back({rec[i], i == rec.size() - 1});
        end
        exp_slot   = a.slot + {16'd0, a.used};
        n_ext      = n_ext + ext;
        n_new_dflt = n_new_dflt + new_dflt;
    endfunction

    // Checks emitted bytes, tracks register writes and encodes accepted actions.
    always @(posedge i_clk) begin : monitor
        t_rec_byte exp;
        act_taken = 1'b0;
        if (!i_rst_n) begin
            cfg          = '{unknown_code: 5'd0, sync_code: 5'd1, threshold: 8'd3};
            exp_slot     = '0;
            dflt_slots   = 8'd1;
            cand_slots   = 8'd1;
            cand_cnt     = 8'd0;
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (rec_ch.valid && rec_ch.ready) begin
                quiet_cycles = 0;
                n_bytes      = n_bytes + 1;
                if (pending_record_bytes.size() == 0) begin
                    n_errors = n_errors + 1;
                    $display("%0t: unexpected byte %h last %b", $time,
                             rec_ch.out_byte, rec_ch.last_byte);
                end else begin
                    exp = pending_record_bytes.pop_front();
                    if (rec_ch.out_byte !== exp.data) begin
                        n_errors = n_errors + 1;
                        $display("%0t: out_byte expected %h actual %h", $time,
                                 exp.data, rec_ch.out_byte);
                    end
                    if (rec_ch.last_byte !== exp.last) begin
                        n_errors = n_errors + 1;
                        $display("%0t: last_byte expected %b actual %b", $time,
                                 exp.last, rec_ch.last_byte);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                quiet_cycles = 0;
                case (paddr[3:2])
                    REG_UNKNOWN_CODE: cfg.unknown_code = pwdata[4:0];
                    REG_SYNC_CODE:    cfg.sync_code    = pwdata[4:0];
                    REG_THRESHOLD:    cfg.threshold    = pwdata[7:0];
                    default: ;
                endcase
            end
            if (act_ch.valid && act_ch.ready) begin
                quiet_cycles = 0;
                act_taken    = 1'b1;
                n_actions    = n_actions + 1;
                encode_action({act_ch.status_code, act_ch.custom_code, act_ch.slot_index,
                               act_ch.slot_difference, act_ch.slots_used,
                               act_ch.payload_length});
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin : action_driver
        t_action nxt;
        if (!i_rst_n) begin
            act_ch.valid <= 1'b0;
            src_gap = 0;
        end else if (!act_ch.valid || act_taken) begin
            if (src_gap > 0) begin
                src_gap = src_gap - 1;
                act_ch.valid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                src_gap = $urandom_range(1, 6) - 1;
                act_ch.valid <= 1'b0;
            end else if (actions_to_send.size() != 0) begin
                nxt = actions_to_send.pop_front();
                act_ch.status_code     <= nxt.status;
                act_ch.custom_code     <= nxt.custom;
                act_ch.slot_index      <= nxt.slot;
                act_ch.slot_difference <= nxt.diff;
                act_ch.slots_used      <= nxt.used;
                act_ch.payload_length  <= nxt.plen;
                act_ch.valid <= 1'b1;
            end else begin
                act_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : record_sink
        if (!i_rst_n) begin
            rec_ch.ready <= 1'b0;
            snk_stall = 0;
        end else if (snk_stall > 0) begin
            snk_stall = snk_stall - 1;
            rec_ch.ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            snk_stall = $urandom_range(1, 6) - 1;
            rec_ch.ready <= 1'b0;
        end else begin
            rec_ch.ready <= 1'b1;
        end
    end

    task automatic q_act(input logic [4:0] st, input logic [9:0] cu, input logic [23:0] sl,
                         input logic [15:0] df, input logic [7:0] us, input logic [15:0] pl);
        actions_to_send.push_back('{status: st, custom: cu, slot: sl, diff: df, used: us,
                                    plen: pl});
        gen_next_slot = sl + {16'd0, us};
    endtask

    // Mostly well-formed runs (slot as expected, a sticky slot count that gets
    // promoted) mixed with slot jumps, offsets, payloads and odd counts.
    task automatic queue_random(input int count);
        logic [4:0]  st;
        logic [23:0] sl;
        logic [15:0] df;
        logic [7:0]  us;
        logic [15:0] pl;
        repeat (count) begin
            case ($urandom_range(0, 5))
                0:       st = cfg.unknown_code;
                1:       st = cfg.sync_code;
                default: st = 5'($urandom_range(0, 31));
            endcase
            case ($urandom_range(0, 7))
                0:       sl = 24'($urandom());
                1:       sl = 24'(24'hFFFFFF - $urandom_range(0, 3));
                default: sl = gen_next_slot;
            endcase
            df = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'd0;
            if ($urandom_range(0, 9) == 0) begin
                pref_used = 8'($urandom_range(0, 255));
            end
            case ($urandom_range(0, 5))
                0:       us = 8'd1;
                1:       us = 8'($urandom_range(0, 255));
                default: us = pref_used;
            endcase
            case ($urandom_range(0, 5))
                0:       pl = 16'hFFFF;
                1, 2:    pl = 16'($urandom_range(1, 65535));
                default: pl = 16'd0;
            endcase
            q_act(st, 10'($urandom_range(0, 1023)), sl, df, us, pl);
        end
    endtask

    task automatic wait_drained();
        while (actions_to_send.size() != 0 || act_ch.valid ||
               pending_record_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input logic [4:0] unk, input logic [4:0] sync,
                                input logic [7:0] thr);
        wait_drained();
        apb_write(REG_UNKNOWN_CODE, {27'd0, unk});
        apb_write(REG_SYNC_CODE, {27'd0, sync});
        apb_write(REG_THRESHOLD, {24'd0, thr});
    endtask

    initial begin
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        act_ch.valid           = 1'b0;
        act_ch.status_code     = '0;
        act_ch.custom_code     = '0;
        act_ch.slot_index      = '0;
        act_ch.slot_difference = '0;
        act_ch.slots_used      = '0;
        act_ch.payload_length  = '0;
        rec_ch.ready           = 1'b0;
        gen_next_slot          = '0;
        pref_used              = 8'd2;
        idle_pct               = 25;
        n_actions              = 0;
        n_bytes                = 0;
        n_ext                  = 0;
        n_new_dflt             = 0;
        n_errors               = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed records with the reset register values.
        q_act(5'd2, 10'h000, gen_next_slot, 16'h0000, 8'd1, 16'h0000);
        q_act(5'd0, 10'h3FF, gen_next_slot, 16'h0000, 8'd1, 16'h0000);
        q_act(5'd0, 10'h000, gen_next_slot, 16'h0000, 8'd1, 16'h0000);
        q_act(5'd1, 10'h155, gen_next_slot, 16'h0000, 8'd1, 16'h0000);
        q_act(5'd31, 10'h2AA, 24'hFFFFFF, 16'h8000, 8'd255, 16'hFFFF);
        q_act(5'd4, 10'h000, gen_next_slot, 16'h7FFF, 8'd0, 16'h0001);
        q_act(5'd5, 10'h000, 24'hFFFFFF, 16'h0000, 8'd1, 16'h0000);
        q_act(5'd6, 10'h000, gen_next_slot, 16'h0000, 8'd1, 16'h0000);
        q_act(5'd7, 10'h000, gen_next_slot, 16'h0000, 8'd4, 16'h0000);
        q_act(5'd8, 10'h000, gen_next_slot, 16'h0000, 8'd4, 16'h0000);
        q_act(5'd9, 10'h000, gen_next_slot, 16'h0000, 8'd4, 16'h0000);
        q_act(5'd12, 10'h000, gen_next_slot, 16'h0000, 8'd4, 16'h0000);
        q_act(5'd10, 10'h000, gen_next_slot, 16'hFFFF, 8'd4, 16'h0000);
        q_act(5'd11, 10'h000, gen_next_slot, 16'h0000, 8'd4, 16'h8000);
        q_act(5'd16, 10'h000, gen_next_slot, 16'h0000, 8'd1, 16'h0000);
        q_act(5'd0, 10'h2AA, gen_next_slot, 16'h0000, 8'd7, 16'h0000);
        q_act(5'd0, 10'h2AA, gen_next_slot, 16'h0000, 8'd7, 16'h0000);
        q_act(5'd0, 10'h155, gen_next_slot ^ 24'h800000, 16'h1234, 8'd7, 16'hABCD);
        q_act(5'd1, 10'h000, gen_next_slot, 16'h0000, 8'd7, 16'h0000);
        q_act(5'd21, 10'h3FF, gen_next_slot, 16'h0000, 8'd7, 16'h0000);

        // One code for both roles, and promotion on the second occurrence.
        write_config(5'd31, 5'd31, 8'd1);
        idle_pct = 30;
        queue_random(50);

        write_config(5'd5, 5'd0, 8'd255);
        idle_pct = 0;
        queue_random(40);

        write_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     8'($urandom_range(2, 254)));
        idle_pct = 40;
        queue_random(50);

        write_config(5'd0, 5'd1, 8'd2);
        idle_pct = 0;
        queue_random(50);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Encoded %0d actions into %0d bytes under five register settings.",
                 n_actions, n_bytes);
        $display("%0d records carried an extended header, %0d changed the default.",
                 n_ext, n_new_dflt);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
